// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/ttw_pkg.sv -----
// types, constants and helper functions of the twist to wheel command unit
package ttw_pkg;

    localparam int CAL_POINTS = 5;
    localparam int NPTS       = 5;
    localparam int QDEPTH     = 2;

    // quotient bit counts of the three divisions
    localparam logic [5:0] Q_TOP   = 6'd40;
    localparam logic [5:0] Q_SPEED = 6'd30;
    localparam logic [5:0] Q_PCT   = 6'd7;

    typedef enum logic [2:0] {
        REG_TRACK_WIDTH = 3'd0,
        REG_MAX_LINEAR  = 3'd1,
        REG_MAX_ANGULAR = 3'd2,
        REG_FULL_SCALE  = 3'd3,
        REG_CAL_LEVELS  = 3'd4,
        REG_CAL_SPEEDS  = 3'd5,
        REG_CAL_POINTS  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] track_width;
        logic [14:0] max_linear;
        logic [14:0] max_angular;
        logic [15:0] full_scale_level;
        logic [63:0] cal_levels_packed;
        logic [63:0] cal_speeds_packed;
        logic [2:0]  cal_points_used;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] v;
        logic signed [15:0] w;
        logic               run;
        logic               headlight;
        logic               cfg_err;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [5:0]  qbits;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef logic [NPTS-1:0][15:0] t_pts;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_KIN, S_ABS, S_MMUL, S_MGO, S_MDIV, S_CMPMUL, S_CMP,
        S_SMUL, S_SGO, S_SDIV, S_PSEG, S_PMA, S_PMB, S_PMD, S_PCHK, S_PGO,
        S_PDIV, S_PSIGN, S_OUT
    } t_state;

    function automatic t_pts cal_levels(input t_cfg c);
        t_pts p;
        p[0] = 16'd0;
        for (int i = 1; i < NPTS; i++) begin
            p[i] = c.cal_levels_packed[16*(i-1) +: 16];
        end
        return p;
    endfunction

    function automatic t_pts cal_speeds(input t_cfg c);
        t_pts p;
        p[0] = 16'd0;
        for (int i = 1; i < NPTS; i++) begin
            p[i] = c.cal_speeds_packed[16*(i-1) +: 16];
        end
        return p;
    endfunction

    function automatic logic cfg_ok(input t_cfg c);
        t_pts        lv;
        t_pts        sp;
        logic        ok;
        logic [15:0] last;
        lv = cal_levels(c);
        sp = cal_speeds(c);
        ok = (c.track_width != 16'd0) && (c.max_linear != 15'd0) &&
             (c.max_angular != 15'd0) && (c.full_scale_level != 16'd0) &&
             (c.cal_points_used >= 3'd2) &&
             (c.cal_points_used <= 3'(CAL_POINTS));
        last = 16'd0;
        for (int i = 1; i < NPTS; i++) begin
            if (3'(i) < c.cal_points_used) begin
                if (lv[i] <= lv[i-1] || sp[i] <= sp[i-1]) begin
                    ok = 1'b0;
                end
                last = lv[i];
            end
        end
        if (last > c.full_scale_level) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // upper end of the segment holding a value, from its compares with the points
    function automatic logic [2:0] seg_up(input logic [NPTS-1:0] gt, input logic [2:0] n);
        logic [2:0] up;
        up = 3'd1;
        for (int i = 1; i < NPTS - 1; i++) begin
            if (up == 3'(i) && 3'(i + 1) < n && gt[i]) begin
                up = 3'(i + 1);
            end
        end
        return up;
    endfunction

endpackage

// ----- rtl/ttw_front.sv -----
// front end: accepts twist words, clamps them and classifies them for the queue
module ttw_front (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_linear_velocity,
    input  logic signed [15:0] i_angular_velocity,
    input  logic               i_brake,
    input  logic               i_headlight_in,
    input  ttw_pkg::t_cfg      i_cfg,
    input  logic               i_q_full,
    output logic               o_push,
    output ttw_pkg::t_cmd      o_cmd
);

    logic               ok;
    logic signed [15:0] ml;
    logic signed [15:0] ma;

    always_comb begin
        ok = ttw_pkg::cfg_ok(i_cfg);
        ml = $signed({1'b0, i_cfg.max_linear});
        ma = $signed({1'b0, i_cfg.max_angular});

        o_cmd.v = i_linear_velocity;
        if (i_linear_velocity > ml) begin
            o_cmd.v = ml;
        end else if (i_linear_velocity < -ml) begin
            o_cmd.v = -ml;
        end
        o_cmd.w = i_angular_velocity;
        if (i_angular_velocity > ma) begin
            o_cmd.w = ma;
        end else if (i_angular_velocity < -ma) begin
            o_cmd.w = -ma;
        end
        // braked or bad calibration words skip the arithmetic
        o_cmd.run       = ok && !i_brake;
        o_cmd.headlight = i_headlight_in;
        o_cmd.cfg_err   = !ok;

        o_ready = !i_q_full;
        o_push  = i_valid && !i_q_full;
    end

endmodule

// ----- rtl/ttw_queue.sv -----
// small fifo between front end and back end
module ttw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output ttw_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(ttw_pkg::QDEPTH);

    ttw_pkg::t_cmd        r_mem [ttw_pkg::QDEPTH];
    logic [PW-1:0]        r_wp;
    logic [PW-1:0]        r_rp;
    logic [PW:0]          r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (PW+1)'(ttw_pkg::QDEPTH);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/ttw_div.sv -----
// restoring divider, one quotient bit per cycle
module ttw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttw_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_quot
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_dsh;
    logic [63:0] r_q;

    assign o_done = r_busy && (r_cnt == 6'd0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.qbits;
        end else if (r_busy) begin
            if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dsh <= i_req.divisor << (i_req.qbits - 6'd1);
            r_q   <= 64'd0;
        end else if (r_busy && r_cnt != 6'd0) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_q   <= {r_q[62:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

// ----- rtl/ttw_back.sv -----
// back end: sequencer for wheel speeds, top speed scaling and percent mapping
module ttw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ttw_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  ttw_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [7:0]  o_left_percent,
    output logic signed [7:0]  o_right_percent,
    output logic               o_headlight_out,
    output logic               o_config_error
);

    ttw_pkg::t_state    r_state;
    ttw_pkg::t_state    n_state;
    ttw_pkg::t_pts      lv;
    ttw_pkg::t_pts      sp;
    ttw_pkg::t_div_req  div_req;
    logic               div_done;
    logic [63:0]        div_quot;

    logic signed [15:0] r_v;
    logic signed [15:0] r_w;
    logic               r_hl;
    logic               r_err;
    logic signed [27:0] r_pv;
    logic signed [32:0] r_pw;
    logic signed [33:0] r_l2k;
    logic signed [33:0] r_r2k;
    logic [31:0]        r_la;
    logic [31:0]        r_ra;
    logic [31:0]        r_a;
    logic               r_lneg;
    logic               r_rneg;
    logic [15:0]        r_lvlo;
    logic [15:0]        r_dl;
    logic [15:0]        r_splo;
    logic [15:0]        r_ds;
    logic [63:0]        r_prod;
    logic [40:0]        r_m;
    logic               r_scale;
    logic               r_side;
    logic [29:0]        r_s;
    logic [39:0]        r_num_a;
    logic [39:0]        r_den;
    logic [46:0]        r_num;
    logic [6:0]         r_pct;
    logic [7:0]         r_lp;
    logic [7:0]         r_rp;
    logic               r_out_valid;

    logic [ttw_pkg::NPTS-1:0] gt_f;
    logic [ttw_pkg::NPTS-1:0] gt_s;
    logic [2:0]         up_sel;
    logic [2:0]         lo_sel;
    logic [31:0]        la_c;
    logic [31:0]        ra_c;
    logic [31:0]        x;
    logic               wneg;
    logic [15:0]        fs_off;
    logic [7:0]         pct_signed;
    logic               out_load;

    ttw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        lv = ttw_pkg::cal_levels(i_cfg);
        sp = ttw_pkg::cal_speeds(i_cfg);
        for (int i = 0; i < ttw_pkg::NPTS; i++) begin
            gt_f[i] = i_cfg.full_scale_level > lv[i];
            gt_s[i] = r_s > 30'({sp[i], 8'd0});
        end
        up_sel = (r_state == ttw_pkg::S_PSEG) ? ttw_pkg::seg_up(gt_s, i_cfg.cal_points_used)
                                              : ttw_pkg::seg_up(gt_f, i_cfg.cal_points_used);
        lo_sel = up_sel - 3'd1;
        la_c   = r_l2k[33] ? 32'(-r_l2k) : 32'(r_l2k);
        ra_c   = r_r2k[33] ? 32'(-r_r2k) : 32'(r_r2k);
        x      = r_side ? r_ra : r_la;
        wneg   = r_side ? r_rneg : r_lneg;
        fs_off = i_cfg.full_scale_level - r_lvlo;
        pct_signed = wneg ? 8'(-{1'b0, r_pct}) : {1'b0, r_pct};
        out_load = (r_state == ttw_pkg::S_OUT) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.qbits    = ttw_pkg::Q_TOP;
        div_req.dividend = r_prod;
        div_req.divisor  = {48'd0, r_dl};
        unique case (r_state)
            ttw_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_state = i_cmd.run ? ttw_pkg::S_MUL : ttw_pkg::S_OUT;
                end
            end
            ttw_pkg::S_MUL:    n_state = ttw_pkg::S_KIN;
            ttw_pkg::S_KIN:    n_state = ttw_pkg::S_ABS;
            ttw_pkg::S_ABS:    n_state = ttw_pkg::S_MMUL;
            ttw_pkg::S_MMUL:   n_state = ttw_pkg::S_MGO;
            ttw_pkg::S_MGO: begin
                div_req.start = 1'b1;
                n_state       = ttw_pkg::S_MDIV;
            end
            ttw_pkg::S_MDIV: begin
                if (div_done) begin
                    n_state = ttw_pkg::S_CMPMUL;
                end
            end
            ttw_pkg::S_CMPMUL: n_state = ttw_pkg::S_CMP;
            ttw_pkg::S_CMP:    n_state = ttw_pkg::S_SMUL;
            ttw_pkg::S_SMUL:   n_state = ttw_pkg::S_SGO;
            ttw_pkg::S_SGO: begin
                div_req.start   = 1'b1;
                div_req.qbits   = ttw_pkg::Q_SPEED;
                div_req.divisor = r_scale ? {32'd0, r_a} : 64'd125;
                n_state         = ttw_pkg::S_SDIV;
            end
            ttw_pkg::S_SDIV: begin
                if (div_done) begin
                    n_state = ttw_pkg::S_PSEG;
                end
            end
            ttw_pkg::S_PSEG:   n_state = ttw_pkg::S_PMA;
            ttw_pkg::S_PMA:    n_state = ttw_pkg::S_PMB;
            ttw_pkg::S_PMB:    n_state = ttw_pkg::S_PMD;
            ttw_pkg::S_PMD:    n_state = ttw_pkg::S_PCHK;
            ttw_pkg::S_PCHK: begin
                n_state = (r_num >= 47'(r_den)) ? ttw_pkg::S_PSIGN : ttw_pkg::S_PGO;
            end
            ttw_pkg::S_PGO: begin
                div_req.start   = 1'b1;
                div_req.qbits   = ttw_pkg::Q_PCT;
                div_req.divisor = {23'd0, r_den, 1'b0};
                n_state         = ttw_pkg::S_PDIV;
            end
            ttw_pkg::S_PDIV: begin
                if (div_done) begin
                    n_state = ttw_pkg::S_PSIGN;
                end
            end
            ttw_pkg::S_PSIGN: begin
                n_state = r_side ? ttw_pkg::S_OUT : ttw_pkg::S_SMUL;
            end
            ttw_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = ttw_pkg::S_IDLE;
                end
            end
            default: n_state = ttw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ttw_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    r_v   <= i_cmd.v;
                    r_w   <= i_cmd.w;
                    r_hl  <= i_cmd.headlight;
                    r_err <= i_cmd.cfg_err;
                    r_lp  <= 8'd0;
                    r_rp  <= 8'd0;
                end
            end
            ttw_pkg::S_MUL: begin
                r_pv <= r_v * 28'sd2000;
                r_pw <= r_w * $signed({17'd0, i_cfg.track_width});
            end
            ttw_pkg::S_KIN: begin
                // wheel speeds in units of 1/2000 mm/s
                r_l2k <= 34'(r_pv) - 34'(r_pw);
                r_r2k <= 34'(r_pv) + 34'(r_pw);
            end
            ttw_pkg::S_ABS: begin
                r_la   <= la_c;
                r_ra   <= ra_c;
                r_a    <= (la_c > ra_c) ? la_c : ra_c;
                r_lneg <= r_l2k[33];
                r_rneg <= r_r2k[33];
                r_lvlo <= lv[lo_sel];
                r_dl   <= lv[up_sel] - lv[lo_sel];
                r_splo <= sp[lo_sel];
                r_ds   <= sp[up_sel] - sp[lo_sel];
            end
            ttw_pkg::S_MMUL: begin
                r_prod <= 64'(fs_off) * 64'({r_ds, 8'd0});
            end
            ttw_pkg::S_MDIV: begin
                if (div_done) begin
                    r_m <= 41'({r_splo, 8'd0}) + div_quot[40:0];
                end
            end
            ttw_pkg::S_CMPMUL: begin
                r_prod <= 64'(r_m) * 64'd2000;
            end
            ttw_pkg::S_CMP: begin
                r_scale <= 64'({r_a, 8'd0}) > r_prod;
                r_side  <= 1'b0;
            end
            ttw_pkg::S_SMUL: begin
                // when scaling, the top speed is below 2^30
                if (r_scale) begin
                    r_prod <= 64'(x) * 64'(r_m[29:0]);
                end else begin
                    r_prod <= 64'({x, 4'd0});
                end
            end
            ttw_pkg::S_SDIV: begin
                if (div_done) begin
                    r_s <= div_quot[29:0];
                end
            end
            ttw_pkg::S_PSEG: begin
                r_lvlo <= lv[lo_sel];
                r_dl   <= lv[up_sel] - lv[lo_sel];
                r_splo <= sp[lo_sel];
                r_ds   <= sp[up_sel] - sp[lo_sel];
            end
            ttw_pkg::S_PMA: begin
                r_num_a <= 40'(r_lvlo) * 40'({r_ds, 8'd0});
            end
            ttw_pkg::S_PMB: begin
                r_prod <= 64'(r_s - 30'({r_splo, 8'd0})) * 64'(r_dl);
            end
            ttw_pkg::S_PMD: begin
                r_den <= 40'({r_ds, 8'd0}) * 40'(i_cfg.full_scale_level);
                r_num <= 47'(r_num_a) + r_prod[46:0];
            end
            ttw_pkg::S_PCHK: begin
                if (r_num >= 47'(r_den)) begin
                    r_pct <= 7'd100;
                end else begin
                    // round to nearest: (200 num + den) / (2 den)
                    r_prod <= 64'(r_num[39:0]) * 64'd200 + 64'(r_den);
                end
            end
            ttw_pkg::S_PDIV: begin
                if (div_done) begin
                    r_pct <= div_quot[6:0];
                end
            end
            ttw_pkg::S_PSIGN: begin
                if (r_side) begin
                    r_rp <= pct_signed;
                end else begin
                    r_lp <= pct_signed;
                end
                r_side <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register, refilled while the previous word is being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_left_percent  <= $signed(r_lp);
            o_right_percent <= $signed(r_rp);
            o_headlight_out <= r_hl;
            o_config_error  <= r_err;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- rtl/twist_to_wheel_command_unit.sv -----
// Differential-drive inverse kinematics: a twist word (linear mm/s, yaw mrad/s,
// brake, headlight) becomes signed whole-percent commands for the left and right
// wheel, through clamping, top-speed scaling and the calibration table. A word
// that runs the arithmetic goes through the shared one-bit-per-cycle divider
// (40 quotient bits for the top speed, then per wheel 30 for the wheel speed
// and 7 for the percent unless it saturates); a braked word or one seen with an
// invalid calibration skips the arithmetic. A two-entry queue and an output
// register let the input and output sides stall independently.
`include "assert_macros.svh"

module twist_to_wheel_command_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_linear_velocity,
    input  logic signed [15:0] i_angular_velocity,
    input  logic               i_brake,
    input  logic               i_headlight_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [7:0]  o_left_percent,
    output logic signed [7:0]  o_right_percent,
    output logic               o_headlight_out,
    output logic               o_config_error,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_wdata
);

    ttw_pkg::t_cfg r_cfg;
    ttw_pkg::t_cmd front_cmd;
    ttw_pkg::t_cmd q_cmd;
    logic          front_push;
    logic          q_full;
    logic          q_valid;
    logic          back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_width       <= 16'd500;
            r_cfg.max_linear        <= 15'd1000;
            r_cfg.max_angular       <= 15'd1000;
            r_cfg.full_scale_level  <= 16'd1600;
            r_cfg.cal_levels_packed <= 64'd0;
            r_cfg.cal_speeds_packed <= 64'd0;
            r_cfg.cal_points_used   <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (ttw_pkg::t_reg_idx'(i_cfg_idx))
                ttw_pkg::REG_TRACK_WIDTH: r_cfg.track_width       <= i_cfg_wdata[15:0];
                ttw_pkg::REG_MAX_LINEAR:  r_cfg.max_linear        <= i_cfg_wdata[14:0];
                ttw_pkg::REG_MAX_ANGULAR: r_cfg.max_angular       <= i_cfg_wdata[14:0];
                ttw_pkg::REG_FULL_SCALE:  r_cfg.full_scale_level  <= i_cfg_wdata[15:0];
                ttw_pkg::REG_CAL_LEVELS:  r_cfg.cal_levels_packed <= i_cfg_wdata;
                ttw_pkg::REG_CAL_SPEEDS:  r_cfg.cal_speeds_packed <= i_cfg_wdata;
                ttw_pkg::REG_CAL_POINTS:  r_cfg.cal_points_used   <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    ttw_front u_front (
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_linear_velocity  (i_linear_velocity),
        .i_angular_velocity (i_angular_velocity),
        .i_brake            (i_brake),
        .i_headlight_in     (i_headlight_in),
        .i_cfg              (r_cfg),
        .i_q_full           (q_full),
        .o_push             (front_push),
        .o_cmd              (front_cmd)
    );

    ttw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    ttw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (back_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_left_percent  (o_left_percent),
        .o_right_percent (o_right_percent),
        .o_headlight_out (o_headlight_out),
        .o_config_error  (o_config_error)
    );

    `ASSERT_IMPL(a_pct_range, i_clk, i_rst_n, o_valid, (o_left_percent <= 8'sd100) && (o_left_percent >= -8'sd100) && (o_right_percent <= 8'sd100) && (o_right_percent >= -8'sd100), "wheel percent out of range")

    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_config_error, (o_left_percent == 8'sd0) && (o_right_percent == 8'sd0), "nonzero command with config error")

    `ASSERT_CLK(a_no_pop_empty, i_clk, i_rst_n, back_pop |-> q_valid, "pop from empty queue")

endmodule

// ----- tb/sv/tb_twist_to_wheel_command_unit.sv -----
// testbench of the twist to wheel command unit: random twists against a bit-exact predictor
`timescale 1ns / 1ps

module tb_twist_to_wheel_command_unit;
    import ttw_pkg::*;

    typedef struct {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic               brk;
        logic               hl;
    } twist_t;

    typedef struct {
        logic [7:0] lp;
        logic [7:0] rp;
        logic       hl;
        logic       err;
    } wheel_cmd_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 600;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               drv_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] drv_lin = '0;
    logic signed [15:0] drv_ang = '0;
    logic               drv_brk = 1'b0;
    logic               drv_hl = 1'b0;
    logic               o_valid;
    logic               rx_ready = 1'b0;
    logic signed [7:0]  o_left_percent;
    logic signed [7:0]  o_right_percent;
    logic               o_headlight_out;
    logic               o_config_error;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_idx = '0;
    logic [63:0]        cfg_wdata = '0;

    twist_t             twist_q[$];
    wheel_cmd_t         cmd_q[$];
    int                 sent_cnt = 0;
    int                 acc_cnt = 0;
    int                 err_cnt = 0;
    int                 quiet_cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;

    // shadow of the configuration registers
    longint unsigned    m_track = 500;
    longint unsigned    m_max_lin = 1000;
    longint unsigned    m_max_ang = 1000;
    longint unsigned    m_full = 1600;
    longint unsigned    m_cal_lv = 0;
    longint unsigned    m_cal_sp = 0;
    int                 m_points = 2;
    longint unsigned    pt_lv[5];
    longint unsigned    pt_sp[5];

    twist_to_wheel_command_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (drv_valid),
        .o_ready            (o_ready),
        .i_linear_velocity  (drv_lin),
        .i_angular_velocity (drv_ang),
        .i_brake            (drv_brk),
        .i_headlight_in     (drv_hl),
        .o_valid            (o_valid),
        .i_ready            (rx_ready),
        .o_left_percent     (o_left_percent),
        .o_right_percent    (o_right_percent),
        .o_headlight_out    (o_headlight_out),
        .o_config_error     (o_config_error),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit table_valid(int n);
        if (n < 2 || n > CAL_POINTS) return 1'b0;
        pt_lv[0] = 0;
        pt_sp[0] = 0;
        for (int i = 1; i < 5; i++) begin
            pt_lv[i] = (m_cal_lv >> (16 * (i - 1))) & 64'hFFFF;
            pt_sp[i] = (m_cal_sp >> (16 * (i - 1))) & 64'hFFFF;
        end
        for (int i = 1; i < n; i++) begin
            if (pt_lv[i] <= pt_lv[i-1] || pt_sp[i] <= pt_sp[i-1]) return 1'b0;
        end
        return pt_lv[n-1] <= m_full;
    endfunction

    function automatic int seg_top(bit on_speed, longint unsigned val, int n, int sh);
        int up;
        up = 1;
        while (up + 1 < n && val > ((on_speed ? pt_sp[up] : pt_lv[up]) << sh)) up++;
        return up;
    endfunction

    function automatic longint unsigned wheel_percent(longint unsigned s, int n);
        int              up;
        int              lo;
        longint unsigned ds8;
        longint unsigned dl;
        longint unsigned num;
        longint unsigned den;
        up  = seg_top(1'b1, s, n, 8);
        lo  = up - 1;
        ds8 = (pt_sp[up] - pt_sp[lo]) << 8;
        dl  = pt_lv[up] - pt_lv[lo];
        num = pt_lv[lo] * ds8 + (s - (pt_sp[lo] << 8)) * dl;
        den = ds8 * m_full;
        if (num >= den) return 100;
        return (num * 200 + den) / (2 * den);
    endfunction

    function automatic wheel_cmd_t predict_wheels(twist_t t);
        wheel_cmd_t      r;
        int              n;
        bit              ok;
        longint          v;
        longint          w;
        longint          l2k;
        longint          r2k;
        longint unsigned la;
        longint unsigned ra;
        longint unsigned a;
        longint unsigned m;
        longint unsigned ls;
        longint unsigned rs;
        longint unsigned lp;
        longint unsigned rp;
        int              up;
        int              lo;
        n  = m_points;
        ok = m_track != 0 && m_max_lin != 0 && m_max_ang != 0 && m_full != 0 &&
             table_valid(n);
        lp = 0;
        rp = 0;
        if (ok && !t.brk) begin
            v = t.lin;
            w = t.ang;
            if (v > longint'(m_max_lin)) v = m_max_lin;
            if (v < -longint'(m_max_lin)) v = -longint'(m_max_lin);
            if (w > longint'(m_max_ang)) w = m_max_ang;
            if (w < -longint'(m_max_ang)) w = -longint'(m_max_ang);
            l2k = v * 2000 - w * longint'(m_track);
            r2k = v * 2000 + w * longint'(m_track);
            la  = l2k < 0 ? -l2k : l2k;
            ra  = r2k < 0 ? -r2k : r2k;
            a   = la > ra ? la : ra;
            up  = seg_top(1'b0, m_full, n, 0);
            lo  = up - 1;
            m   = (pt_sp[lo] << 8) +
                  ((m_full - pt_lv[lo]) * ((pt_sp[up] - pt_sp[lo]) << 8)) /
                  (pt_lv[up] - pt_lv[lo]);
            if (a * 256 > m * 2000) begin
                ls = la * m / a;
                rs = ra * m / a;
            end else begin
                ls = la * 16 / 125;
                rs = ra * 16 / 125;
            end
            lp = wheel_percent(ls, n);
            rp = wheel_percent(rs, n);
            if (l2k < 0) lp = 0 - lp;
            if (r2k < 0) rp = 0 - rp;
        end
        r.lp  = lp[7:0];
        r.rp  = rp[7:0];
        r.hl  = t.hl;
        r.err = !ok;
        return r;
    endfunction

    // acceptance, prediction, result check and watchdog
    always @(posedge i_clk) begin
        wheel_cmd_t e;
        bit         moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (drv_valid && o_ready) begin
                twist_t t;
                t.lin = drv_lin;
                t.ang = drv_ang;
                t.brk = drv_brk;
                t.hl  = drv_hl;
                cmd_q.push_back(predict_wheels(t));
                acc_cnt++;
                moved = 1'b1;
            end
            if (o_valid && rx_ready) begin
                moved = 1'b1;
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected word l=%0d r=%0d", $time,
                             o_left_percent, o_right_percent);
                    err_cnt++;
                end else begin
                    e = cmd_q.pop_front();
                    if (o_left_percent !== e.lp) begin
                        $display("%0t: left_percent exp %0d got %0d", $time,
                                 $signed(e.lp), o_left_percent);
                        err_cnt++;
                    end
                    if (o_right_percent !== e.rp) begin
                        $display("%0t: right_percent exp %0d got %0d", $time,
                                 $signed(e.rp), o_right_percent);
                        err_cnt++;
                    end
                    if (o_headlight_out !== e.hl) begin
                        $display("%0t: headlight_out exp %0b got %0b", $time,
                                 e.hl, o_headlight_out);
                        err_cnt++;
                    end
                    if (o_config_error !== e.err) begin
                        $display("%0t: config_error exp %0b got %0b", $time,
                                 e.err, o_config_error);
                        err_cnt++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        twist_t t;
        if (i_rst_n && !(drv_valid && acc_cnt != sent_cnt)) begin
            if (twist_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
                t = twist_q.pop_front();
                drv_lin   <= t.lin;
                drv_ang   <= t.ang;
                drv_brk   <= t.brk;
                drv_hl    <= t.hl;
                drv_valid <= 1'b1;
                sent_cnt++;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        int hold_left;
        bit hold_done;
        if (hold_left > 0) begin
            hold_left--;
            rx_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rx_ready  <= 1'b0;
        end else begin
            rx_ready <= calm || $urandom_range(0, 99) >= 28;
        end
    end

    task automatic write_reg(t_reg_idx idx, longint unsigned val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TRACK_WIDTH: m_track   = val & 64'hFFFF;
            REG_MAX_LINEAR:  m_max_lin = val & 64'h7FFF;
            REG_MAX_ANGULAR: m_max_ang = val & 64'h7FFF;
            REG_FULL_SCALE:  m_full    = val & 64'hFFFF;
            REG_CAL_LEVELS:  m_cal_lv  = val;
            REG_CAL_SPEEDS:  m_cal_sp  = val;
            REG_CAL_POINTS:  m_points  = int'(val & 64'h7);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(longint unsigned tw, longint unsigned ml, longint unsigned ma,
                           longint unsigned fs, longint unsigned lvp, longint unsigned spp,
                           int n);
        write_reg(REG_TRACK_WIDTH, tw);
        write_reg(REG_MAX_LINEAR, ml);
        write_reg(REG_MAX_ANGULAR, ma);
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_CAL_LEVELS, lvp);
        write_reg(REG_CAL_SPEEDS, spp);
        write_reg(REG_CAL_POINTS, n);
    endtask

    // increasing table at or below the full-scale level; tight puts the last level on it
    task automatic make_table(longint unsigned fs, int n, bit tight,
                              output longint unsigned lvp, output longint unsigned spp);
        longint unsigned l;
        longint unsigned s;
        longint unsigned lstep;
        longint unsigned sstep;
        lvp   = {$urandom, $urandom};
        spp   = {$urandom, $urandom};
        lstep = fs / (n - 1);
        sstep = 65535 / (n - 1);
        l = 0;
        s = 0;
        for (int i = 1; i < n; i++) begin
            l += $urandom_range(1, int'(lstep));
            s += $urandom_range(1, int'(sstep));
            if (tight && i == n - 1) l = fs;
            lvp[16*(i-1) +: 16] = l[15:0];
            spp[16*(i-1) +: 16] = s[15:0];
        end
    endtask

    task automatic add_twist(int lin, int ang, bit brk, bit hl);
        twist_t t;
        t.lin = lin;
        t.ang = ang;
        t.brk = brk;
        t.hl  = hl;
        twist_q.push_back(t);
    endtask

    task automatic add_random(int count);
        int lim_l;
        int lim_a;
        int lin;
        int ang;
        lim_l = int'(m_max_lin) + 4;
        lim_a = int'(m_max_ang) + 4;
        if (lim_l > 32767) lim_l = 32767;
        if (lim_a > 32767) lim_a = 32767;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
                lin = $signed(16'($urandom));
                ang = $signed(16'($urandom));
            end else begin
                lin = $urandom_range(0, 2 * lim_l) - lim_l;
                ang = $urandom_range(0, 2 * lim_a) - lim_a;
                if ($urandom_range(0, 3) == 0) ang = 0;
            end
            add_twist(lin, ang, $urandom_range(0, 99) < 12, $urandom_range(0, 1));
        end
    endtask

    task automatic drain();
        while (twist_q.size() != 0 || acc_cnt != sent_cnt || drv_valid ||
               cmd_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        longint unsigned lvp;
        longint unsigned spp;
        longint unsigned fs;
        int              n;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset table is all zero, so every word flags a bad calibration
        add_twist(100, 50, 1'b0, 1'b1);
        add_twist(-100, 0, 1'b1, 1'b0);
        add_twist(0, 0, 1'b0, 1'b0);
        drain();

        set_all(500, 1000, 1000, 1600, 64'h0640_04B0_0320_0190,
                64'h03E8_02EE_01F4_00FA, 5);
        add_twist(0, 0, 1'b0, 1'b0);
        add_twist(32767, 0, 1'b0, 1'b1);
        add_twist(-32768, 0, 1'b0, 1'b0);
        add_twist(0, 32767, 1'b0, 1'b1);
        add_twist(0, -32768, 1'b0, 1'b0);
        add_twist(32767, 32767, 1'b0, 1'b0);
        add_twist(-32768, -32768, 1'b0, 1'b1);
        add_twist(-32768, 32767, 1'b0, 1'b0);
        add_twist(500, 0, 1'b0, 1'b0);
        add_twist(-500, 0, 1'b0, 1'b1);
        add_twist(250, 0, 1'b0, 1'b0);
        add_twist(999, 0, 1'b0, 1'b0);
        add_twist(1000, 1000, 1'b0, 1'b0);
        add_twist(1000, -1000, 1'b0, 1'b1);
        add_twist(-1, 0, 1'b0, 1'b0);
        add_twist(0, 1, 1'b0, 1'b0);
        add_twist(1, -1, 1'b0, 1'b1);
        add_twist(3, 0, 1'b0, 1'b0);
        add_twist(800, 200, 1'b1, 1'b1);
        add_twist(32767, -32768, 1'b1, 1'b0);
        drain();

        for (int p = 0; p < 10; p++) begin
            fs = $urandom_range(8, 65535);
            n  = $urandom_range(2, 5);
            make_table(fs, n, $urandom_range(0, 1), lvp, spp);
            case (p)
                0: begin
                    make_table(65535, 5, 1'b1, lvp, spp);
                    set_all(65535, 32767, 32767, 65535, lvp, spp, 5);
                end
                1: set_all(1, 1, 1, 1, 64'h0000_0000_0000_0001, 64'hFFFF, 2);
                2: set_all(500, 1000, 1000, fs, lvp, spp,
                           ($urandom_range(0, 1) ? 0 : 6) + $urandom_range(0, 1));
                3: set_all(0, 0, 0, 0, lvp, spp, n);
                7: set_all(500, 1000, 1000, fs, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF, 5);
                default: set_all($urandom_range(1, 65535), $urandom_range(1, 32767),
                                 $urandom_range(1, 32767), fs, lvp, spp, n);
            endcase
            if (p == 4) begin
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            if (p == 6) calm = 1'b1;
            add_random(25);
            if (p == 5) begin
                // sender stops until every result is back
                while (twist_q.size() != 0 || acc_cnt != sent_cnt || drv_valid ||
                       cmd_q.size() != 0) begin
                    @(negedge i_clk);
                end
            end
            add_random(25);
            drain();
            calm = 1'b0;
        end

        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ttw_pkg.sv
rtl/ttw_front.sv
rtl/ttw_queue.sv
rtl/ttw_div.sv
rtl/ttw_back.sv
rtl/twist_to_wheel_command_unit.sv
tb/sv/tb_twist_to_wheel_command_unit.sv
